// File: src/aet_pkg.sv
package aet_pkg;

    localparam logic [2:0] KIND_NUMBER = 3'd0;
    localparam logic [2:0] KIND_OPEN   = 3'd1;
    localparam logic [2:0] KIND_CLOSE  = 3'd2;
    localparam logic [2:0] KIND_PLUS   = 3'd3;
    localparam logic [2:0] KIND_MINUS  = 3'd4;
    localparam logic [2:0] KIND_TIMES  = 3'd5;
    localparam logic [2:0] KIND_END    = 3'd6;

    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_OPEN  = 8'h28;
    localparam logic [7:0] CHAR_CLOSE = 8'h29;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_TIMES = 8'h2A;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [63:0] value;
        logic               last;
    } token_t;

endpackage

// File: src/arithmetic_expression_tokenizer.sv
// path: a character is registered in the input stage (char_reg), its tokens are then
// written into the token queue, and the output shows the oldest token in the queue
// throughput: one character per cycle while each character yields at most one
// token and out_ready stays high; a character that yields two tokens grows the queue
// reset: rst_n asynchronous, active low; expression start armed, no number pending
module arithmetic_expression_tokenizer
    import aet_pkg::*;
#(
    parameter int VALUE_BITS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         char_code,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         token_kind,
    output logic signed [63:0] number_value,
    output logic               last_of_run
);

    localparam int WIDE_BITS = VALUE_BITS + 4;
    localparam logic [WIDE_BITS-1:0] CAP_WIDE = WIDE_BITS'(1) << (VALUE_BITS - 1);
    localparam logic [VALUE_BITS-1:0] POS_MAX = {1'b0, {(VALUE_BITS - 1){1'b1}}};

    // input stage
    logic       stage_valid_reg;
    logic [7:0] char_reg;

    // tokenizer state
    logic                  start_reg, start_next;
    logic                  pending_reg, pending_next;
    logic                  negative_reg, negative_next;
    logic [VALUE_BITS-1:0] mag_reg, mag_next;

    // token queue
    token_t              queue_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QUEUE_AW:0]   count_reg, count_next;

    logic                  advance;
    logic                  pop;
    logic                  flush;
    logic                  emit_op;
    logic [2:0]            op_kind;
    logic [1:0]            n_tokens;
    logic [3:0]            digit;
    logic [WIDE_BITS-1:0]  wide;
    logic [VALUE_BITS-1:0] flush_val;
    logic signed [VALUE_BITS-1:0] flush_signed;
    token_t                num_tok;
    token_t                op_tok;
    token_t                tok0;
    token_t                tok1;

    assign advance  = stage_valid_reg && (count_reg <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 2));
    assign in_ready = !stage_valid_reg || advance;
    assign pop      = out_valid && out_ready;

    assign digit = (char_reg[3:0] > 4'd9) ? 4'd9 : char_reg[3:0];
    assign wide  = (WIDE_BITS'(mag_reg) << 3) + (WIDE_BITS'(mag_reg) << 1)
                 + WIDE_BITS'(digit);

    always_comb
    begin
        if (negative_reg)
        begin
            flush_val = VALUE_BITS'(0) - mag_reg;
        end
        else if (mag_reg[VALUE_BITS-1])
        begin
            flush_val = POS_MAX;
        end
        else
        begin
            flush_val = mag_reg;
        end
    end

    assign flush_signed = signed'(flush_val);

    always_comb
    begin
        flush         = 1'b0;
        emit_op       = 1'b0;
        op_kind       = KIND_END;
        start_next    = start_reg;
        pending_next  = pending_reg;
        negative_next = negative_reg;
        mag_next      = mag_reg;
        case (char_reg) inside
            CHAR_DOT, CHAR_OPEN, CHAR_CLOSE, CHAR_PLUS, CHAR_TIMES:
            begin
                flush         = pending_reg;
                pending_next  = 1'b0;
                negative_next = 1'b0;
                mag_next      = '0;
                start_next    = 1'b0;
                emit_op       = 1'b1;
                case (char_reg)
                    CHAR_DOT:
                    begin
                        op_kind    = KIND_END;
                        start_next = 1'b1;
                    end
                    CHAR_OPEN:
                    begin
                        op_kind    = KIND_OPEN;
                        start_next = 1'b1;
                    end
                    CHAR_CLOSE:
                    begin
                        op_kind = KIND_CLOSE;
                    end
                    CHAR_PLUS:
                    begin
                        op_kind = KIND_PLUS;
                        emit_op = !start_reg;
                    end
                    default:
                    begin
                        op_kind = KIND_TIMES;
                    end
                endcase
            end
            CHAR_MINUS:
            begin
                start_next = 1'b0;
                if (start_reg)
                begin
                    pending_next  = 1'b1;
                    negative_next = 1'b1;
                    mag_next      = '0;
                end
                else
                begin
                    flush         = pending_reg;
                    emit_op       = 1'b1;
                    op_kind       = KIND_MINUS;
                    pending_next  = 1'b0;
                    negative_next = 1'b0;
                    mag_next      = '0;
                end
            end
            default:
            begin
                start_next   = 1'b0;
                pending_next = 1'b1;
                if (wide > CAP_WIDE)
                begin
                    mag_next = CAP_WIDE[VALUE_BITS-1:0];
                end
                else
                begin
                    mag_next = wide[VALUE_BITS-1:0];
                end
            end
        endcase
    end

    always_comb
    begin
        num_tok.kind  = KIND_NUMBER;
        num_tok.value = 64'(flush_signed);
        num_tok.last  = !emit_op;
        op_tok.kind   = op_kind;
        op_tok.value  = '0;
        op_tok.last   = 1'b1;
        tok0          = flush ? num_tok : op_tok;
        tok1          = op_tok;
        n_tokens      = 2'(flush) + 2'(emit_op);
    end

    always_comb
    begin
        count_next = count_reg;
        if (advance)
        begin
            count_next = count_next + (QUEUE_AW + 1)'(n_tokens);
        end
        if (pop)
        begin
            count_next = count_next - (QUEUE_AW + 1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            start_reg       <= 1'b1;
            pending_reg     <= 1'b0;
            negative_reg    <= 1'b0;
            mag_reg         <= '0;
            wr_ptr_reg      <= '0;
            rd_ptr_reg      <= '0;
            count_reg       <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                stage_valid_reg <= in_valid;
            end
            if (advance)
            begin
                start_reg    <= start_next;
                pending_reg  <= pending_next;
                negative_reg <= negative_next;
                mag_reg      <= mag_next;
                wr_ptr_reg   <= wr_ptr_reg + QUEUE_AW'(n_tokens);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg <= char_code;
        end
        if (advance && (n_tokens != 2'd0))
        begin
            queue_reg[wr_ptr_reg] <= tok0;
        end
        if (advance && (n_tokens == 2'd2))
        begin
            queue_reg[wr_ptr_reg + QUEUE_AW'(1)] <= tok1;
        end
    end

    assign out_valid    = (count_reg != '0);
    assign token_kind   = queue_reg[rd_ptr_reg].kind;
    assign number_value = queue_reg[rd_ptr_reg].value;
    assign last_of_run  = queue_reg[rd_ptr_reg].last;

endmodule

// File: verif/tb_arithmetic_expression_tokenizer.sv
`timescale 1ns / 1ps

module tb_arithmetic_expression_tokenizer;
    import aet_pkg::*;

    localparam int          VALUE_BITS   = 64;
    localparam int          CLK_PERIOD   = 10;
    localparam int          RANDOM_CHARS = 1700;
    localparam int          DRAIN_CYCLES = 12;
    localparam int          CYCLE_LIMIT  = 500000;
    localparam logic [63:0] MAG_CAP      = 64'd1 << (VALUE_BITS - 1);
    localparam logic [63:0] POS_MAX      = MAG_CAP - 64'd1;
    localparam logic [63:0] NEG_MIN      = 64'd0 - MAG_CAP;

    typedef struct {
        logic [7:0]  ch;
        int          rep;
        bit          known;
        bit          has_num;
        logic [63:0] num;
        logic [2:0]  kind;
    } stim_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         char_code = 8'h00;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [2:0]         token_kind;
    logic signed [63:0] number_value;
    logic               last_of_run;

    // predictor state
    bit          expr_start = 1'b1;
    bit          num_pending = 1'b0;
    bit          num_negative = 1'b0;
    logic [63:0] magnitude = 64'd0;

    token_t      tokens_due[$];
    token_t      step_tokens[$];
    logic [7:0]  char_stream[$];
    stim_row_t   stim_table[$];

    int          mismatches = 0;
    int          chars_sent = 0;
    int          tokens_seen = 0;
    int          pos_saturations = 0;
    int          neg_saturations = 0;
    int          lone_minus_flushes = 0;
    int          cycle_count = 0;
    bit          quiet_in = 1'b0;
    bit          quiet_out = 1'b0;

    arithmetic_expression_tokenizer #(.VALUE_BITS(VALUE_BITS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_code    (char_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .number_value (number_value),
        .last_of_run  (last_of_run)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d tokens outstanding", cycle_count,
                     tokens_due.size());
            $display("tb_arithmetic_expression_tokenizer: done, errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    function automatic token_t mk_token(input logic [2:0] kind, input logic [63:0] value);
        token_t t;
        t.kind  = kind;
        t.value = value;
        t.last  = 1'b0;
        return t;
    endfunction

    task automatic flush_number();
        logic [63:0] v;
        if (!num_pending)
            return;
        if (num_negative)
        begin
            v = 64'd0 - magnitude;
            if (magnitude == MAG_CAP)
                neg_saturations++;
            if (magnitude == 64'd0)
                lone_minus_flushes++;
        end
        else
        begin
            v = magnitude;
            if (v > POS_MAX)
            begin
                v = POS_MAX;
                pos_saturations++;
            end
        end
        step_tokens = {step_tokens, mk_token(KIND_NUMBER, v)};
        num_pending  = 1'b0;
        num_negative = 1'b0;
        magnitude    = 64'd0;
    endtask

    task automatic predict_tokens(input logic [7:0] c, input bit record);
        logic [7:0] offset;
        logic [3:0] digit;
        step_tokens.delete();
        case (c)
            CHAR_DOT:
            begin
                flush_number();
                step_tokens = {step_tokens, mk_token(KIND_END, 64'd0)};
                expr_start = 1'b1;
            end
            CHAR_OPEN:
            begin
                flush_number();
                step_tokens = {step_tokens, mk_token(KIND_OPEN, 64'd0)};
                expr_start = 1'b1;
            end
            CHAR_CLOSE:
            begin
                flush_number();
                step_tokens = {step_tokens, mk_token(KIND_CLOSE, 64'd0)};
                expr_start = 1'b0;
            end
            CHAR_PLUS:
            begin
                flush_number();
                if (!expr_start)
                    step_tokens = {step_tokens, mk_token(KIND_PLUS, 64'd0)};
                expr_start = 1'b0;
            end
            CHAR_MINUS:
            begin
                if (expr_start)
                begin
                    num_pending  = 1'b1;
                    num_negative = 1'b1;
                    magnitude    = 64'd0;
                end
                else
                begin
                    flush_number();
                    step_tokens = {step_tokens, mk_token(KIND_MINUS, 64'd0)};
                end
                expr_start = 1'b0;
            end
            CHAR_TIMES:
            begin
                flush_number();
                step_tokens = {step_tokens, mk_token(KIND_TIMES, 64'd0)};
                expr_start = 1'b0;
            end
            default:
            begin
                offset = c - 8'h30;
                digit  = (offset[3:0] > 4'd9) ? 4'd9 : offset[3:0];
                if (magnitude > (MAG_CAP - 64'(digit)) / 64'd10)
                    magnitude = MAG_CAP;
                else
                    magnitude = magnitude * 64'd10 + 64'(digit);
                num_pending = 1'b1;
                expr_start  = 1'b0;
            end
        endcase
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        if (record)
            foreach (step_tokens[i])
                tokens_due = {tokens_due, step_tokens[i]};
    endtask

    task automatic send_char(input logic [7:0] c, input bit record);
        int gap;
        if ($urandom_range(0, 47) == 0)
            quiet_in = !quiet_in;
        gap = quiet_in ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        chars_sent++;
        predict_tokens(c, record);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic row_checked(input logic [7:0] ch, input int rep);
        stim_row_t r;
        r.ch      = ch;
        r.rep     = rep;
        r.known   = 1'b0;
        r.has_num = 1'b0;
        r.num     = 64'd0;
        r.kind    = KIND_NUMBER;
        stim_table = {stim_table, r};
    endtask

    task automatic row_known(input logic [7:0] ch, input bit has_num, input logic [63:0] num,
                             input logic [2:0] kind);
        stim_row_t r;
        r.ch      = ch;
        r.rep     = 1;
        r.known   = 1'b1;
        r.has_num = has_num;
        r.num     = num;
        r.kind    = kind;
        stim_table = {stim_table, r};
    endtask

    function automatic logic [7:0] any_digit_byte();
        logic [7:0] b;
        if ($urandom_range(0, 15) != 0)
            return 8'h30 + 8'($urandom_range(0, 9));
        do
            b = 8'($urandom_range(0, 255));
        while (b == CHAR_DOT || b == CHAR_OPEN || b == CHAR_CLOSE || b == CHAR_PLUS
               || b == CHAR_MINUS || b == CHAR_TIMES);
        return b;
    endfunction

    function automatic void gen_number();
        int len;
        len = ($urandom_range(0, 11) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 4);
        repeat (len) char_stream = {char_stream, any_digit_byte()};
    endfunction

    function automatic void gen_expr(input int depth);
        int terms;
        int roll;
        terms = $urandom_range(1, 4);
        for (int t = 0; t < terms; t++)
        begin
            if (t > 0)
            begin
                case ($urandom_range(0, 2))
                    0:       char_stream = {char_stream, CHAR_PLUS};
                    1:       char_stream = {char_stream, CHAR_MINUS};
                    default: char_stream = {char_stream, CHAR_TIMES};
                endcase
            end
            roll = $urandom_range(0, 9);
            if (roll < 3)
                char_stream = {char_stream, CHAR_MINUS};
            else if (roll == 3)
                char_stream = {char_stream, CHAR_PLUS};
            if (depth < 3 && $urandom_range(0, 3) == 0)
            begin
                char_stream = {char_stream, CHAR_OPEN};
                gen_expr(depth + 1);
                char_stream = {char_stream, CHAR_CLOSE};
            end
            else
                gen_number();
        end
    endfunction

    // output side: random stalls, compare each transaction with the oldest expected token
    initial
    begin : token_monitor
        int     stall;
        token_t want;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 47) == 0)
                quiet_out = !quiet_out;
            stall = quiet_out ? 0 : $urandom_range(0, 8);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            tokens_seen++;
            if (tokens_due.size() == 0)
                report_mismatch($sformatf("unexpected token kind %0d value %0d last %0b",
                                          token_kind, number_value, last_of_run));
            else
            begin
                want = tokens_due.pop_front();
                if (token_kind !== want.kind)
                    report_mismatch($sformatf("token_kind %0d, expected %0d",
                                              token_kind, want.kind));
                if (number_value !== want.value)
                    report_mismatch($sformatf("number_value %0d, expected %0d",
                                              number_value, want.value));
                if (last_of_run !== want.last)
                    report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                              last_of_run, want.last));
            end
        end
    end

    initial
    begin : stimulus
        int roll;

        // known answers where obvious, predictor elsewhere
        row_known(CHAR_DOT, 1'b0, 64'd0, KIND_END);
        row_checked(CHAR_PLUS, 1);
        row_known(CHAR_OPEN, 1'b0, 64'd0, KIND_OPEN);
        row_checked(CHAR_MINUS, 1);
        row_known(CHAR_CLOSE, 1'b1, 64'd0, KIND_CLOSE);
        row_known(CHAR_MINUS, 1'b0, 64'd0, KIND_MINUS);
        row_known(CHAR_TIMES, 1'b0, 64'd0, KIND_TIMES);
        row_known(CHAR_OPEN, 1'b0, 64'd0, KIND_OPEN);
        row_checked(CHAR_PLUS, 1);
        row_checked(8'h00, 1);
        row_checked(8'hFF, 1);
        row_checked(CHAR_PLUS, 1);
        row_checked("9", 19);
        row_known(CHAR_TIMES, 1'b1, POS_MAX, KIND_TIMES);
        row_known(CHAR_OPEN, 1'b0, 64'd0, KIND_OPEN);
        row_checked(CHAR_MINUS, 1);
        row_checked("9", 19);
        row_known(CHAR_CLOSE, 1'b1, NEG_MIN, KIND_CLOSE);
        row_checked("4", 1);
        row_checked("2", 1);
        row_checked(CHAR_MINUS, 1);
        row_checked("a", 1);
        row_checked(CHAR_DOT, 1);
        row_checked(CHAR_MINUS, 1);
        row_checked("7", 1);
        row_checked(CHAR_DOT, 1);

        while (char_stream.size() < RANDOM_CHARS)
        begin
            roll = $urandom_range(0, 7);
            if (roll == 0)
                repeat ($urandom_range(1, 6))
                    char_stream = {char_stream, 8'($urandom_range(0, 255))};
            else
            begin
                gen_expr(0);
                if (roll != 1)
                    char_stream = {char_stream, CHAR_DOT};
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (stim_table[i])
        begin
            repeat (stim_table[i].rep) send_char(stim_table[i].ch, !stim_table[i].known);
            if (stim_table[i].known)
            begin
                if (stim_table[i].has_num)
                    tokens_due = {tokens_due, mk_token(KIND_NUMBER, stim_table[i].num)};
                tokens_due = {tokens_due, mk_token(stim_table[i].kind, 64'd0)};
                tokens_due[tokens_due.size() - 1].last = 1'b1;
            end
        end
        wait_drained();

        foreach (char_stream[i])
        begin
            // hold off now and then until every pending token is out
            if (i % 500 == 499)
                wait_drained();
            send_char(char_stream[i], 1'b1);
        end
        wait_drained();

        $display("sent %0d characters, checked %0d tokens", chars_sent, tokens_seen);
        $display("saturated numbers: %0d positive, %0d negative; lone minus flushes: %0d",
                 pos_saturations, neg_saturations, lone_minus_flushes);
        if (mismatches == 0)
            $display("tb_arithmetic_expression_tokenizer: done, clean");
        else
            $display("tb_arithmetic_expression_tokenizer: done, errors");
        $finish;
    end

endmodule

// File: arithmetic_expression_tokenizer.f
src/aet_pkg.sv
src/arithmetic_expression_tokenizer.sv
verif/tb_arithmetic_expression_tokenizer.sv
